// ===== hw/rtl/sfrf_pkg.sv =====
// shared types and constants for the stereo frame ring fifo
// no dependencies
package sfrf_pkg;

  localparam int DEPTH_FRAMES_DEF = 1024;

  localparam int ACTION_W = 2;
  localparam int SAMPLE_W = 32;
  localparam int SKIP_W   = 10;
  localparam int STATUS_W = 2;
  localparam int FR_W     = 11;
  localparam int FRAME_W  = 2 * SAMPLE_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/sfrf_if.sv =====
// valid/ready channel interfaces for action and result transactions
// depends on sfrf_pkg
interface sfrf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [sfrf_pkg::ACTION_W-1:0]         action;
  logic signed [sfrf_pkg::SAMPLE_W-1:0]  left_sample;
  logic signed [sfrf_pkg::SAMPLE_W-1:0]  right_sample;
  logic [sfrf_pkg::SKIP_W-1:0]           skip_frames;

  modport source (output valid, action, left_sample, right_sample, skip_frames,
                  input ready);
  modport sink (input valid, action, left_sample, right_sample, skip_frames,
                output ready);
endinterface

interface sfrf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [sfrf_pkg::STATUS_W-1:0]         status;
  logic signed [sfrf_pkg::SAMPLE_W-1:0]  left_out;
  logic signed [sfrf_pkg::SAMPLE_W-1:0]  right_out;
  logic [sfrf_pkg::FR_W-1:0]             frames_readable;

  modport source (output valid, status, left_out, right_out, frames_readable,
                  input ready);
  modport sink (input valid, status, left_out, right_out, frames_readable,
                output ready);
endinterface

// ===== hw/rtl/sfrf_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module sfrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/stereo_frame_ring_fifo.sv =====
// stereo frame ring fifo with peek: push, pop, peek at offset, clear
// results pass through the s1 stage register and then the output register; one transaction per cycle while not stalled
// the frame ram read is registered with the s1 stage; the output register holds a result while the receiver stalls
// synchronous active-low reset empties the ring; frame ram contents are not cleared
// depends on sfrf_pkg, sfrf_if, sfrf_ram
module stereo_frame_ring_fifo #(
  parameter int DEPTH_FRAMES = sfrf_pkg::DEPTH_FRAMES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sfrf_in_if.sink   in_chan,
  sfrf_out_if.source out_chan
);

  localparam int IDX_W = $clog2(DEPTH_FRAMES);
  localparam int PTR_W = IDX_W + 1;
  localparam int CMP_W = (PTR_W > sfrf_pkg::SKIP_W) ? PTR_W : sfrf_pkg::SKIP_W;
  localparam int SUM_W = (IDX_W > sfrf_pkg::SKIP_W) ? IDX_W : sfrf_pkg::SKIP_W;
  localparam int OCC_W = (PTR_W > sfrf_pkg::FR_W) ? PTR_W : sfrf_pkg::FR_W;
  localparam int SW    = sfrf_pkg::SAMPLE_W;

  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PTR_W-1:0] occ, occ_after;
  logic [OCC_W-1:0] occ_ext;
  logic [CMP_W-1:0] skip_ext, occ_cmp;
  logic [SUM_W-1:0] peek_sum;
  logic             full, empty, peek_miss;

  logic             in_acc, out_free, s1_move;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [sfrf_pkg::FRAME_W-1:0] rd_data;
  sfrf_pkg::status_t st;

  logic                       s1_v_r, s1_v_nxt, s1_rd_r;
  sfrf_pkg::status_t          s1_status_r;
  logic [sfrf_pkg::FR_W-1:0]  s1_fr_r;

  logic                       out_v_r, out_v_nxt;
  sfrf_pkg::status_t          out_status_r;
  logic signed [SW-1:0]       out_left_r, out_right_r;
  logic [sfrf_pkg::FR_W-1:0]  out_fr_r;

  assign occ       = wp_r - rp_r;
  assign full      = occ[PTR_W-1];
  assign empty     = (occ == '0);
  assign skip_ext  = CMP_W'(in_chan.skip_frames);
  assign occ_cmp   = CMP_W'(occ);
  assign peek_miss = (skip_ext >= occ_cmp);
  assign peek_sum  = SUM_W'(rp_r[IDX_W-1:0]) + SUM_W'(in_chan.skip_frames);

  assign out_free = !out_v_r || out_chan.ready;
  assign s1_move  = s1_v_r && out_free;
  assign in_chan.ready = !s1_v_r || out_free;
  assign in_acc   = in_chan.valid && in_chan.ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    st      = sfrf_pkg::ST_DONE;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = rp_r[IDX_W-1:0];
    case (in_chan.action)
      sfrf_pkg::ACT_PUSH: begin
        if (full) begin
          st = sfrf_pkg::ST_FULL;
        end else begin
          wr_en  = in_acc;
          wp_nxt = wp_r + PTR_W'(1);
        end
      end
      sfrf_pkg::ACT_POP: begin
        if (empty) begin
          st = sfrf_pkg::ST_NONE;
        end else begin
          rd_en  = in_acc;
          rp_nxt = rp_r + PTR_W'(1);
        end
      end
      sfrf_pkg::ACT_PEEK: begin
        rd_addr = peek_sum[IDX_W-1:0];
        if (peek_miss) begin
          st = sfrf_pkg::ST_NONE;
        end else begin
          rd_en = in_acc;
        end
      end
      sfrf_pkg::ACT_CLEAR: begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      default: begin
        wp_nxt = wp_r;
      end
    endcase
    occ_after = wp_nxt - rp_nxt;
    occ_ext   = OCC_W'(occ_after);
  end

  sfrf_ram #(
    .WIDTH (sfrf_pkg::FRAME_W),
    .DEPTH (DEPTH_FRAMES)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r[IDX_W-1:0]),
    .wr_data ({in_chan.left_sample, in_chan.right_sample}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s1_v_nxt  = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_move ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (in_acc) begin
        wp_r <= wp_nxt;
        rp_r <= rp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= st;
      s1_rd_r     <= rd_en;
      s1_fr_r     <= occ_ext[sfrf_pkg::FR_W-1:0];
    end
    if (s1_move) begin
      out_status_r <= s1_status_r;
      out_fr_r     <= s1_fr_r;
      out_left_r   <= s1_rd_r ? rd_data[2*SW-1:SW] : '0;
      out_right_r  <= s1_rd_r ? rd_data[SW-1:0] : '0;
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.left_out        = out_left_r;
  assign out_chan.right_out       = out_right_r;
  assign out_chan.frames_readable = out_fr_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) <= PTR_W'(DEPTH_FRAMES))
    else $error("ring occupancy beyond depth");

  a_clear_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_chan.action == sfrf_pkg::ACT_CLEAR |=> wp_r == '0 && rp_r == '0)
    else $error("clear did not reset pointers");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_free |=> s1_v_r && $stable(s1_status_r) && $stable(s1_fr_r))
    else $error("pending transaction lost while output stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && !s1_rd_r |=> out_left_r == '0 && out_right_r == '0)
    else $error("samples not zero for transaction without frame read");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for stereo_frame_ring_fifo: push, pop, peek and clear transactions
// fill the ring past full and wrap the write index, checked against a ring model in the bench
// depends on sfrf_pkg, sfrf_if and the stereo_frame_ring_fifo rtl
module tb_top;

  localparam int RING_DEPTH   = sfrf_pkg::DEPTH_FRAMES_DEF;
  localparam int IDX_W        = $clog2(RING_DEPTH);
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_MAX   = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int SHALLOW_ITEMS = 15;
  localparam int STREAM_ITEMS  = 10;

  typedef struct {
    sfrf_pkg::action_t             act;
    logic [sfrf_pkg::SAMPLE_W-1:0] left;
    logic [sfrf_pkg::SAMPLE_W-1:0] right;
    logic [sfrf_pkg::SKIP_W-1:0]   skip;
  } frame_req_t;

  typedef struct {
    sfrf_pkg::status_t             st;
    logic [sfrf_pkg::SAMPLE_W-1:0] left;
    logic [sfrf_pkg::SAMPLE_W-1:0] right;
    logic [sfrf_pkg::FR_W-1:0]     level;
  } frame_resp_t;

  logic clk = 1'b0;
  logic rst_n;

  sfrf_in_if  in_if ();
  sfrf_out_if out_if ();

  stereo_frame_ring_fifo uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  frame_req_t  pending_req_q[$];
  frame_resp_t due_resp_q[$];

  logic [sfrf_pkg::SAMPLE_W-1:0] ring_left  [RING_DEPTH];
  logic [sfrf_pkg::SAMPLE_W-1:0] ring_right [RING_DEPTH];
  logic [sfrf_pkg::FR_W-1:0]     wr_ptr;
  logic [sfrf_pkg::FR_W-1:0]     rd_ptr;

  int gen_occ;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_left;
  int mismatches;
  int results_seen;
  int cycle_cnt;
  bit req_taken;

  function automatic frame_resp_t apply_to_ring(frame_req_t rq);
    frame_resp_t               rs;
    logic [sfrf_pkg::FR_W-1:0] occ;
    logic [sfrf_pkg::FR_W-1:0] slot;
    occ = wr_ptr - rd_ptr;
    rs.st = sfrf_pkg::ST_DONE;
    rs.left = '0;
    rs.right = '0;
    case (rq.act)
      sfrf_pkg::ACT_PUSH: begin
        if (occ >= RING_DEPTH) begin
          rs.st = sfrf_pkg::ST_FULL;
        end else begin
          ring_left[wr_ptr[IDX_W-1:0]] = rq.left;
          ring_right[wr_ptr[IDX_W-1:0]] = rq.right;
          wr_ptr = wr_ptr + 1'b1;
        end
      end
      sfrf_pkg::ACT_POP: begin
        if (occ == 0) begin
          rs.st = sfrf_pkg::ST_NONE;
        end else begin
          rs.left = ring_left[rd_ptr[IDX_W-1:0]];
          rs.right = ring_right[rd_ptr[IDX_W-1:0]];
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      sfrf_pkg::ACT_PEEK: begin
        if (sfrf_pkg::FR_W'(rq.skip) >= occ) begin
          rs.st = sfrf_pkg::ST_NONE;
        end else begin
          slot = rd_ptr + sfrf_pkg::FR_W'(rq.skip);
          rs.left = ring_left[slot[IDX_W-1:0]];
          rs.right = ring_right[slot[IDX_W-1:0]];
        end
      end
      default: begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
    endcase
    rs.level = wr_ptr - rd_ptr;
    return rs;
  endfunction

  function automatic logic [sfrf_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7, 0))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // occupancy is tracked here only to steer the stimulus
  task automatic queue_req(sfrf_pkg::action_t a, logic [sfrf_pkg::SAMPLE_W-1:0] l,
                           logic [sfrf_pkg::SAMPLE_W-1:0] r,
                           logic [sfrf_pkg::SKIP_W-1:0] s);
    frame_req_t rq;
    rq.act = a;
    rq.left = l;
    rq.right = r;
    rq.skip = s;
    pending_req_q.push_back(rq);
    case (a)
      sfrf_pkg::ACT_PUSH: begin
        if (gen_occ < RING_DEPTH) gen_occ++;
      end
      sfrf_pkg::ACT_POP: begin
        if (gen_occ > 0) gen_occ--;
      end
      sfrf_pkg::ACT_CLEAR: begin
        gen_occ = 0;
      end
      default: ;
    endcase
  endtask

  task automatic queue_random(int w_push, int w_pop, int w_peek, int w_clear);
    int                          roll;
    int                          reach;
    sfrf_pkg::action_t           a;
    logic [sfrf_pkg::SKIP_W-1:0] s;
    roll = $urandom_range(w_push + w_pop + w_peek + w_clear - 1, 0);
    if (roll < w_push) a = sfrf_pkg::ACT_PUSH;
    else if (roll < w_push + w_pop) a = sfrf_pkg::ACT_POP;
    else if (roll < w_push + w_pop + w_peek) a = sfrf_pkg::ACT_PEEK;
    else a = sfrf_pkg::ACT_CLEAR;
    reach = (gen_occ > RING_DEPTH - 1) ? RING_DEPTH - 1 : gen_occ;
    case ($urandom_range(9, 0))
      7: s = sfrf_pkg::SKIP_W'($urandom);
      8: s = (reach == 0) ? '0 : sfrf_pkg::SKIP_W'(reach - 1);
      9: s = sfrf_pkg::SKIP_W'(reach);
      default: s = sfrf_pkg::SKIP_W'($urandom_range(reach, 0));
    endcase
    queue_req(a, pick_sample(), pick_sample(), s);
  endtask

  task set_idle(int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
  endtask

  task wait_idle();
    while (pending_req_q.size() != 0 || due_resp_q.size() != 0) @(posedge clk);
  endtask

  // input side: transaction accepted at the rising edge
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (rst_n && in_if.valid && in_if.ready) begin
      due_resp_q.push_back(apply_to_ring(pending_req_q.pop_front()));
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || req_taken) begin
      if (pending_req_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.action <= pending_req_q[0].act;
        in_if.left_sample <= pending_req_q[0].left;
        in_if.right_sample <= pending_req_q[0].right;
        in_if.skip_frames <= pending_req_q[0].skip;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_resp_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_resp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d with no transaction pending: status %0d level %0d",
                   results_seen, out_if.status, out_if.frames_readable);
      end else begin
        want = due_resp_q.pop_front();
        if (out_if.status !== want.st || out_if.left_out !== want.left ||
            out_if.right_out !== want.right || out_if.frames_readable !== want.level) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result %0d: want st %0d l %h r %h lvl %0d, got st %0d l %h r %h lvl %0d",
                     results_seen, want.st, want.left, want.right, want.level,
                     out_if.status, out_if.left_out, out_if.right_out,
                     out_if.frames_readable);
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int seg;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = sfrf_pkg::ACT_PUSH;
    in_if.left_sample = '0;
    in_if.right_sample = '0;
    in_if.skip_frames = '0;
    out_if.ready = 1'b0;
    wr_ptr = '0;
    rd_ptr = '0;
    gen_occ = 0;
    hold_req = 0;
    hold_left = 0;
    mismatches = 0;
    results_seen = 0;
    cycle_cnt = 0;
    set_idle(0, 0);

    // empty ring, extremes, peek bounds, clear
    queue_req(sfrf_pkg::ACT_POP, 32'h1234_5678, 32'h9abc_def0, 10'h3ff);
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, '0);
    queue_req(sfrf_pkg::ACT_PUSH, 32'h8000_0000, 32'h7fff_ffff, 10'h3ff);
    queue_req(sfrf_pkg::ACT_PUSH, 32'h7fff_ffff, 32'h8000_0000, '0);
    queue_req(sfrf_pkg::ACT_PUSH, '0, '1, 10'h155);
    queue_req(sfrf_pkg::ACT_PUSH, 32'haaaa_aaaa, 32'h5555_5555, 10'h2aa);
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, 10'd0);
    queue_req(sfrf_pkg::ACT_PEEK, '1, '1, 10'd3);
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, 10'd4);
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, 10'h3ff);
    queue_req(sfrf_pkg::ACT_POP, '0, '0, '0);
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, 10'd0);
    queue_req(sfrf_pkg::ACT_CLEAR, '1, '1, 10'h3ff);
    queue_req(sfrf_pkg::ACT_POP, '0, '0, '0);
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, 10'd0);
    queue_req(sfrf_pkg::ACT_PUSH, 32'h0000_0001, 32'hffff_fffe, '0);
    queue_req(sfrf_pkg::ACT_POP, '0, '0, '0);
    queue_req(sfrf_pkg::ACT_POP, '0, '0, '0);
    queue_req(sfrf_pkg::ACT_PUSH, '1, '0, '0);
    queue_req(sfrf_pkg::ACT_CLEAR, '0, '0, '0);
    queue_req(sfrf_pkg::ACT_PUSH, 32'hdead_beef, 32'h0bad_f00d, '0);
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, 10'd0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // shallow mixed traffic under each idling pattern
    hold_req = HOLD_CYCLES;
    set_idle(0, 0);
    repeat (SHALLOW_ITEMS) queue_random(40, 30, 25, 5);
    wait_idle();
    set_idle(51, 0);
    repeat (SHALLOW_ITEMS) queue_random(40, 30, 25, 5);
    wait_idle();
    set_idle(0, 51);
    repeat (SHALLOW_ITEMS) queue_random(40, 30, 25, 5);
    wait_idle();
    set_idle(11, 11);
    repeat (SHALLOW_ITEMS) queue_random(40, 30, 25, 5);
    wait_idle();

    // fill to full, then push against the full ring
    set_idle(0, 0);
    queue_req(sfrf_pkg::ACT_CLEAR, pick_sample(), pick_sample(),
              sfrf_pkg::SKIP_W'($urandom));
    while (gen_occ < RING_DEPTH) queue_random(96, 0, 4, 0);
    repeat (3) queue_req(sfrf_pkg::ACT_PUSH, pick_sample(), pick_sample(),
                         sfrf_pkg::SKIP_W'($urandom));
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, 10'h3ff);
    queue_req(sfrf_pkg::ACT_PEEK, '0, '0, 10'd0);
    queue_req(sfrf_pkg::ACT_POP, '0, '0, '0);
    queue_req(sfrf_pkg::ACT_PUSH, pick_sample(), pick_sample(), '0);
    queue_req(sfrf_pkg::ACT_PUSH, pick_sample(), pick_sample(), '0);
    wait_idle();

    // stream near full with the write index past its wrap
    seg = 0;
    while (seg < 4) begin
      case (seg)
        0: set_idle(0, 0);
        1: set_idle(51, 0);
        2: set_idle(0, 51);
        default: set_idle(11, 11);
      endcase
      repeat (STREAM_ITEMS) queue_random(50, 45, 5, 0);
      wait_idle();
      seg++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_resp_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sfrf_pkg.sv
hw/rtl/sfrf_if.sv
hw/rtl/sfrf_ram.sv
hw/rtl/stereo_frame_ring_fifo.sv
test/tb_top.sv
